// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/bfcg_pkg.sv =====
// Package: constants, mode codes and control structs of the byte FIFO with chunk gate.
`timescale 1ns / 1ps

package bfcg_pkg;

    localparam int DEPTH       = 8192;
    localparam int ROOM_MARGIN = 1024;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int FILL_W      = 14;
    localparam int CNT_W       = 20;
    localparam int CHUNK_MOD   = 1000000;
    localparam int RELEASE_MIN = 2;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_GET   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic latch_item;
        logic exec;
        logic calc;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== design/bfcg_datapath.sv =====
// Datapath: byte memory, pointers, chunk counters, hold register and result register.
`timescale 1ns / 1ps

module bfcg_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfcg_pkg::cmd_t                cmd,
    output bfcg_pkg::status_t             status,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    data_byte,
    input  logic                          chunk_end,
    input  logic                          cfg_valid,
    input  logic [bfcg_pkg::CNT_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    read_byte,
    output logic                          read_valid,
    output logic                          write_taken,
    output logic [bfcg_pkg::FILL_W-1:0]   fill_bytes,
    output logic [bfcg_pkg::CNT_W-1:0]    chunk_count,
    output logic                          insert_ok,
    output logic                          get_ok
);

    localparam logic [bfcg_pkg::PTR_W-1:0] ROOM_LIMIT =
        bfcg_pkg::PTR_W'(bfcg_pkg::DEPTH - bfcg_pkg::ROOM_MARGIN);
    localparam logic [bfcg_pkg::CNT_W-1:0] CNT_LAST =
        bfcg_pkg::CNT_W'(bfcg_pkg::CHUNK_MOD - 1);
    localparam logic [bfcg_pkg::CNT_W-1:0] CNT_MOD =
        bfcg_pkg::CNT_W'(bfcg_pkg::CHUNK_MOD);
    localparam logic [bfcg_pkg::CNT_W-1:0] CNT_MIN =
        bfcg_pkg::CNT_W'(bfcg_pkg::RELEASE_MIN);

    logic [7:0]                   mem [bfcg_pkg::DEPTH];
    logic [7:0]                   mem_q_reg;
    logic                         mem_we;
    logic                         mem_re;
    logic [bfcg_pkg::ADDR_W-1:0]  mem_addr;

    logic [1:0]                   mode_reg;
    logic [7:0]                   data_reg;
    logic                         end_reg;

    logic [bfcg_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bfcg_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bfcg_pkg::CNT_W-1:0]   wchunk_reg, wchunk_next;
    logic [bfcg_pkg::CNT_W-1:0]   rchunk_reg, rchunk_next;
    logic [bfcg_pkg::CNT_W-1:0]   hold_reg;
    logic [bfcg_pkg::CNT_W-1:0]   count_reg;
    logic                         taken_reg;
    logic                         rvalid_reg;
    logic                         out_valid_reg;

    logic [7:0]                   read_byte_reg;
    logic                         read_valid_reg;
    logic                         write_taken_reg;
    logic [bfcg_pkg::FILL_W-1:0]  fill_bytes_reg;
    logic [bfcg_pkg::CNT_W-1:0]   chunk_count_reg;
    logic                         insert_ok_reg;
    logic                         get_ok_reg;

    logic [bfcg_pkg::PTR_W-1:0]   fill;
    logic                         full;
    logic                         empty;
    logic                         room;
    logic                         do_put;
    logic                         do_get;

    function automatic logic [bfcg_pkg::CNT_W-1:0] chunk_adv(
        input logic [bfcg_pkg::CNT_W-1:0] c
    );
        return (c == CNT_LAST) ? '0 : c + 1'b1;
    endfunction

    assign fill   = wr_ptr_reg - rd_ptr_reg;
    assign full   = fill[bfcg_pkg::PTR_W-1];
    assign empty  = (fill == '0);
    assign room   = (fill <= ROOM_LIMIT);
    assign do_put = cmd.exec && (mode_reg == bfcg_pkg::MODE_PUT);
    assign do_get = cmd.exec && (mode_reg == bfcg_pkg::MODE_GET);

    assign mem_we   = do_put && !full;
    assign mem_re   = do_get && !empty;
    assign mem_addr = mem_we ? wr_ptr_reg[bfcg_pkg::ADDR_W-1:0]
                             : rd_ptr_reg[bfcg_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= data_reg;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        wchunk_next = wchunk_reg;
        rchunk_next = rchunk_reg;
        if (cmd.exec)
        begin
            unique case (mode_reg)
                bfcg_pkg::MODE_PUT:
                begin
                    if (!full)
                    begin
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                    if (end_reg)
                    begin
                        wchunk_next = chunk_adv(wchunk_reg);
                    end
                end
                bfcg_pkg::MODE_GET:
                begin
                    if (!empty)
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                    if (end_reg)
                    begin
                        rchunk_next = chunk_adv(rchunk_reg);
                    end
                end
                bfcg_pkg::MODE_CLEAR:
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    wchunk_next = '0;
                    rchunk_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            wchunk_reg    <= '0;
            rchunk_reg    <= '0;
            hold_reg      <= bfcg_pkg::CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            wchunk_reg <= wchunk_next;
            rchunk_reg <= rchunk_next;
            if (cfg_valid)
            begin
                hold_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            mode_reg <= mode;
            data_reg <= data_byte;
            end_reg  <= chunk_end;
        end
        if (cmd.exec)
        begin
            taken_reg  <= mem_we;
            rvalid_reg <= mem_re;
        end
        if (cmd.calc)
        begin
            // counters stay below the modulus, so one wrap-around add suffices
            count_reg <= (wchunk_reg >= rchunk_reg) ? wchunk_reg - rchunk_reg
                                                    : wchunk_reg - rchunk_reg + CNT_MOD;
        end
        if (cmd.load_out)
        begin
            read_byte_reg   <= rvalid_reg ? mem_q_reg : 8'h00;
            read_valid_reg  <= rvalid_reg;
            write_taken_reg <= taken_reg;
            fill_bytes_reg  <= bfcg_pkg::FILL_W'(fill);
            chunk_count_reg <= count_reg;
            insert_ok_reg   <= room;
            get_ok_reg      <= (count_reg >= CNT_MIN) && ((count_reg > hold_reg) || !room);
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign read_byte   = read_byte_reg;
    assign read_valid  = read_valid_reg;
    assign write_taken = write_taken_reg;
    assign fill_bytes  = fill_bytes_reg;
    assign chunk_count = chunk_count_reg;
    assign insert_ok   = insert_ok_reg;
    assign get_ok      = get_ok_reg;

endmodule

// ===== design/bfcg_ctrl.sv =====
// Controller: sequences accept, execute, status calculation and result load per item.
`timescale 1ns / 1ps

module bfcg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfcg_pkg::status_t   status,
    output bfcg_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_CALC = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.latch_item = 1'b0;
        cmd.exec       = 1'b0;
        cmd.calc       = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // wait here until the result register can take the new result
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/byte_fifo_with_chunk_gate.sv =====
// Top level: circular byte FIFO with chunk counting and reader release gate.
// Items are handled one at a time by the accept/execute/status/load sequencer, which takes
// no new input transfer until the current result is loaded into the result register.
// The single-port byte memory is read through a register.
// A pending result blocks the next input transfer, since it holds off the current item's load.
// Reset (rst_n, async low) clears pointers, chunk counters, result valid; hold_level = 1.
`timescale 1ns / 1ps

module byte_fifo_with_chunk_gate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    data_byte,
    input  logic                          chunk_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    read_byte,
    output logic                          read_valid,
    output logic                          write_taken,
    output logic [bfcg_pkg::FILL_W-1:0]   fill_bytes,
    output logic [bfcg_pkg::CNT_W-1:0]    chunk_count,
    output logic                          insert_ok,
    output logic                          get_ok,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfcg_pkg::CNT_W-1:0]    cfg_data
);

    bfcg_pkg::cmd_t    cmd;
    bfcg_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bfcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bfcg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .data_byte   (data_byte),
        .chunk_end   (chunk_end),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_byte   (read_byte),
        .read_valid  (read_valid),
        .write_taken (write_taken),
        .fill_bytes  (fill_bytes),
        .chunk_count (chunk_count),
        .insert_ok   (insert_ok),
        .get_ok      (get_ok)
    );

endmodule

// ===== design/bfcg_checker.sv =====
// Port-level checker for the byte FIFO with chunk gate, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfcg_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          read_valid,
    input  logic                          write_taken,
    input  logic [bfcg_pkg::CNT_W-1:0]    chunk_count,
    input  logic                          get_ok
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // one item in flight: no transfer right after an input transfer
    `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    // a step is either a get or a put, never both
    `ASSERT_IMPLY(a_op_excl, clk, rst_n, out_valid && read_valid, !write_taken)
    // the reader is never released with fewer than two chunks
    `ASSERT_IMPLY(a_release_min, clk, rst_n, out_valid && get_ok,
                  chunk_count >= bfcg_pkg::CNT_W'(bfcg_pkg::RELEASE_MIN))

endmodule

bind byte_fifo_with_chunk_gate bfcg_checker u_bfcg_checker (.*);

// ===== tb/tb_byte_fifo_with_chunk_gate.sv =====
// Testbench: byte FIFO with chunk gate, checked item by item against a shadow model.
`timescale 1ns / 1ps

module tb_byte_fifo_with_chunk_gate;

    localparam logic [1:0] MODE_NOP  = 2'd3;  // unused code, status only
    localparam int         IDLE_WAIT = 8;
    localparam int         CYCLE_CAP = 4_000_000;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       last;
    } fifo_op_t;

    typedef struct packed {
        logic [7:0]                  rbyte;
        logic                        rvalid;
        logic                        taken;
        logic [bfcg_pkg::FILL_W-1:0] fill;
        logic [bfcg_pkg::CNT_W-1:0]  chunks;
        logic                        ins;
        logic                        gok;
    } fifo_status_t;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_ready;
    logic [1:0]                  mode       = MODE_NOP;
    logic [7:0]                  data_byte  = '0;
    logic                        chunk_end  = 1'b0;
    logic                        out_valid;
    logic                        out_ready  = 1'b0;
    logic [7:0]                  read_byte;
    logic                        read_valid;
    logic                        write_taken;
    logic [bfcg_pkg::FILL_W-1:0] fill_bytes;
    logic [bfcg_pkg::CNT_W-1:0]  chunk_count;
    logic                        insert_ok;
    logic                        get_ok;
    logic                        cfg_valid  = 1'b0;
    logic                        cfg_ready;
    logic [bfcg_pkg::CNT_W-1:0]  cfg_data   = '0;

    byte_fifo_with_chunk_gate dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .data_byte   (data_byte),
        .chunk_end   (chunk_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_byte   (read_byte),
        .read_valid  (read_valid),
        .write_taken (write_taken),
        .fill_bytes  (fill_bytes),
        .chunk_count (chunk_count),
        .insert_ok   (insert_ok),
        .get_ok      (get_ok),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    // shadow state of the buffer
    logic [7:0]                 shadow_mem [bfcg_pkg::DEPTH];
    logic [bfcg_pkg::PTR_W-1:0] shadow_wr      = '0;
    logic [bfcg_pkg::PTR_W-1:0] shadow_rd      = '0;
    logic [bfcg_pkg::CNT_W-1:0] shadow_wchunks = '0;
    logic [bfcg_pkg::CNT_W-1:0] shadow_rchunks = '0;
    logic [bfcg_pkg::CNT_W-1:0] shadow_hold    = 20'd1;

    fifo_op_t     op_backlog [$];
    fifo_status_t status_expected [$];

    int n_queued     = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_dropped    = 0;
    int n_empty_gets = 0;
    int n_clears     = 0;
    int peak_fill    = 0;
    int err_cnt      = 0;
    int cycles       = 0;

    function automatic logic [bfcg_pkg::CNT_W-1:0] chunk_next(
        input logic [bfcg_pkg::CNT_W-1:0] c
    );
        return (c == bfcg_pkg::CNT_W'(bfcg_pkg::CHUNK_MOD - 1)) ? '0 : c + 1'b1;
    endfunction

    task automatic fifo_shadow_step(input fifo_op_t op, output fifo_status_t st);
        logic [bfcg_pkg::PTR_W-1:0] level;
        int unsigned                pend;
        st    = '0;
        level = shadow_wr - shadow_rd;
        case (op.mode)
            bfcg_pkg::MODE_PUT:
            begin
                if (level < bfcg_pkg::PTR_W'(bfcg_pkg::DEPTH))
                begin
                    shadow_mem[shadow_wr[bfcg_pkg::ADDR_W-1:0]] = op.data;
                    shadow_wr = shadow_wr + 1'b1;
                    st.taken  = 1'b1;
                end
                else
                    n_dropped++;
                if (op.last)
                    shadow_wchunks = chunk_next(shadow_wchunks);
            end
            bfcg_pkg::MODE_GET:
            begin
                if (level != '0)
                begin
                    st.rbyte  = shadow_mem[shadow_rd[bfcg_pkg::ADDR_W-1:0]];
                    st.rvalid = 1'b1;
                    shadow_rd = shadow_rd + 1'b1;
                end
                else
                    n_empty_gets++;
                if (op.last)
                    shadow_rchunks = chunk_next(shadow_rchunks);
            end
            bfcg_pkg::MODE_CLEAR:
            begin
                shadow_wr      = '0;
                shadow_rd      = '0;
                shadow_wchunks = '0;
                shadow_rchunks = '0;
                n_clears++;
            end
            default: ;
        endcase
        level   = shadow_wr - shadow_rd;
        st.fill = level;
        if (int'(level) > peak_fill)
            peak_fill = int'(level);
        if (shadow_wchunks >= shadow_rchunks)
            pend = int'(shadow_wchunks) - int'(shadow_rchunks);
        else
            pend = int'(shadow_wchunks) + bfcg_pkg::CHUNK_MOD - int'(shadow_rchunks);
        st.chunks = bfcg_pkg::CNT_W'(pend);
        st.ins    = (int'(level) <= bfcg_pkg::DEPTH - bfcg_pkg::ROOM_MARGIN);
        if (pend < bfcg_pkg::RELEASE_MIN)
            st.gok = 1'b0;
        else if (pend > int'(shadow_hold))
            st.gok = 1'b1;
        else
            st.gok = !st.ins;
    endtask

    task automatic add_op(input logic [1:0] m, input logic [7:0] d, input logic last);
        fifo_op_t op;
        op.mode = m;
        op.data = d;
        op.last = last;
        op_backlog.push_back(op);
        n_queued++;
    endtask

    // well-formed put/get chunks with random content, plus clears and noise
    task automatic queue_traffic(input int target);
        int added;
        int len;
        int pick;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_op(bfcg_pkg::MODE_PUT, 8'($urandom), i == len - 1);
                added += len;
            end
            else if (pick < 75)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_op(bfcg_pkg::MODE_GET, 8'($urandom), i == len - 1);
                added += len;
            end
            else if (pick < 80)
            begin
                add_op(bfcg_pkg::MODE_CLEAR, 8'($urandom), 1'($urandom));
                added++;
            end
            else if (pick < 85)
                add_op(MODE_NOP, 8'($urandom), 1'($urandom));
            else
            begin
                add_op(($urandom_range(0, 1) != 0) ? bfcg_pkg::MODE_PUT : bfcg_pkg::MODE_GET,
                       8'($urandom), 1'($urandom));
                added++;
            end
        end
    endtask

    task automatic queue_run(input int count, input int put_pct);
        for (int i = 0; i < count; i++)
            add_op(($urandom_range(0, 99) < put_pct) ? bfcg_pkg::MODE_PUT : bfcg_pkg::MODE_GET,
                   8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    task automatic wait_idle();
        while (n_checked != n_queued)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_hold(input logic [bfcg_pkg::CNT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_hold = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, want, got);
        end
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge clk)
    begin : drive_items
        int       burst_left;
        int       gap_left;
        fifo_op_t op;
        fifo_status_t st;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                op.mode = mode;
                op.data = data_byte;
                op.last = chunk_end;
                fifo_shadow_step(op, st);
                status_expected.push_back(st);
                n_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (op_backlog.size() > 0)
                begin
                    op = op_backlog.pop_front();
                    mode      <= op.mode;
                    data_byte <= op.data;
                    chunk_end <= op.last;
                    in_valid  <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stalls follow a rotating pattern that is redrawn now and then
    always @(posedge clk)
    begin : watch_results
        logic [15:0]  stall_pat;
        int           pat_age;
        fifo_status_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (status_expected.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result transfer with nothing expected, fill %0d",
                             $time, fill_bytes);
                end
                else
                begin
                    want = status_expected.pop_front();
                    check_field("read_byte", 32'(want.rbyte), 32'(read_byte));
                    check_field("read_valid", 32'(want.rvalid), 32'(read_valid));
                    check_field("write_taken", 32'(want.taken), 32'(write_taken));
                    check_field("fill_bytes", 32'(want.fill), 32'(fill_bytes));
                    check_field("chunk_count", 32'(want.chunks), 32'(chunk_count));
                    check_field("insert_ok", 32'(want.ins), 32'(insert_ok));
                    check_field("get_ok", 32'(want.gok), 32'(get_ok));
                    n_checked++;
                end
            end
            if (pat_age == 0)
            begin
                pat_age = $urandom_range(40, 160);
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'($urandom) | 16'($urandom);
                    default: stall_pat = (16'($urandom) & 16'($urandom)) | 16'h0100;
                endcase
            end
            else
                pat_age--;
            out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("%0t: timeout, %0d of %0d results seen", $time, n_checked, n_queued);
            $display("tb_byte_fifo_with_chunk_gate: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset hold level
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b0);       // get on empty
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b1);       // empty get still ends a chunk
        add_op(bfcg_pkg::MODE_PUT, 8'h00, 1'b0);
        add_op(bfcg_pkg::MODE_PUT, 8'hFF, 1'b1);
        add_op(bfcg_pkg::MODE_PUT, 8'hA5, 1'b1);
        add_op(MODE_NOP, 8'h5A, 1'b1);                 // unused code ignores chunk_end
        add_op(bfcg_pkg::MODE_PUT, 8'h5A, 1'b1);
        add_op(bfcg_pkg::MODE_GET, 8'hFF, 1'b0);
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b0);
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b0);
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b1);
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b1);
        add_op(bfcg_pkg::MODE_CLEAR, 8'h00, 1'b1);     // clear ignores chunk_end
        add_op(bfcg_pkg::MODE_PUT, 8'h81, 1'b1);
        add_op(bfcg_pkg::MODE_PUT, 8'h7E, 1'b1);
        add_op(bfcg_pkg::MODE_PUT, 8'h3C, 1'b1);
        add_op(MODE_NOP, 8'hC3, 1'b0);
        add_op(bfcg_pkg::MODE_CLEAR, 8'hFF, 1'b0);
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b0);
        add_op(bfcg_pkg::MODE_PUT, 8'hC3, 1'b0);
        add_op(bfcg_pkg::MODE_GET, 8'h00, 1'b1);
        wait_idle();

        write_hold(20'd0);
        queue_traffic(220);
        wait_idle();

        write_hold(20'd999999);
        queue_traffic(220);
        wait_idle();

        // long put run past the hold level, then drain past empty
        write_hold(20'd20);
        queue_run(180, 100);
        queue_run(80, 50);
        queue_run(200, 0);
        add_op(bfcg_pkg::MODE_CLEAR, 8'h00, 1'b0);
        wait_idle();

        write_hold(20'd2);
        queue_traffic(170);
        wait_idle();

        write_hold(20'd3);
        queue_traffic(170);
        wait_idle();

        $display("%0d items sent, %0d results checked, %0d clears, peak fill %0d",
                 n_sent, n_checked, n_clears, peak_fill);
        $display("%0d puts dropped on full, %0d gets on empty; hold levels 1/0/999999/20/2/3",
                 n_dropped, n_empty_gets);
        if (err_cnt == 0)
            $display("tb_byte_fifo_with_chunk_gate: done, clean");
        else
            $display("tb_byte_fifo_with_chunk_gate: done, errors");
        $finish;
    end

endmodule
